// ===== rtl/core/cubemap_gradient_texel_defines.svh =====
// cubemap_gradient_texel_defines.svh: assertion macros for the sky texel checker.
// No dependencies; included by the checker file.
`ifndef CUBEMAP_GRADIENT_TEXEL_DEFINES_SVH
`define CUBEMAP_GRADIENT_TEXEL_DEFINES_SVH

// assertion sampled on the clock, off while reset is asserted
`define CGT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion that also holds across reset
`define CGT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cgt_pkg.sv =====
// cgt_pkg: types, constants and step functions of the sky texel pipeline.
// No dependencies; used by every module of the block.
`default_nettype none
package cgt_pkg;

    localparam int COLOR_FRAC_BITS = 16;
    localparam logic [16:0] ONE_Q  = 17'(1 << COLOR_FRAC_BITS);
    localparam logic [16:0] HALF_Q = 17'(1 << (COLOR_FRAC_BITS - 1));

    // configuration register indexes
    localparam logic [2:0] CFG_FACE_SIZE    = 3'd0;
    localparam logic [2:0] CFG_TOP_RED      = 3'd1;
    localparam logic [2:0] CFG_TOP_GREEN    = 3'd2;
    localparam logic [2:0] CFG_TOP_BLUE     = 3'd3;
    localparam logic [2:0] CFG_BOTTOM_RED   = 3'd4;
    localparam logic [2:0] CFG_BOTTOM_GREEN = 3'd5;
    localparam logic [2:0] CFG_BOTTOM_BLUE  = 3'd6;

    localparam logic [12:0] RST_FACE_SIZE    = 13'd256;
    localparam logic [16:0] RST_TOP_RED      = 17'd32768;
    localparam logic [16:0] RST_TOP_GREEN    = 17'd45875;
    localparam logic [16:0] RST_TOP_BLUE     = 17'd65536;
    localparam logic [16:0] RST_BOTTOM_RED   = 17'd58982;
    localparam logic [16:0] RST_BOTTOM_GREEN = 17'd58982;
    localparam logic [16:0] RST_BOTTOM_BLUE  = 17'd52429;

    // face codes
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_LAST  = 3'd5;

    localparam int DIV_STAGES  = 33;
    localparam int SQRT_STAGES = 17;

    typedef struct packed {
        logic [2:0]  face;
        logic [11:0] column;
        logic [11:0] row;
    } t_texel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [16:0] red;
        logic [16:0] green;
        logic [16:0] blue;
    } t_color;

    // per-texel flags that ride along the pipeline
    typedef struct packed {
        logic up;   // face code above five: straight up
        logic neg;  // numerator of dir_y is negative
    } t_tag;

    typedef struct packed {
        logic [27:0] rem;
        logic        bit_q;
    } t_div_step;

    typedef struct packed {
        logic [18:0] rem;
        logic [16:0] root;
    } t_sqrt_step;

    // one bit of restoring division, remainder kept below den
    function automatic t_div_step div_step(input logic [27:0] rem, input logic [27:0] den);
        logic [28:0] dbl;
        logic [28:0] dif;
        t_div_step   s;
        dbl     = {rem, 1'b0};
        dif     = dbl - {1'b0, den};
        s.bit_q = (dbl >= {1'b0, den});
        s.rem   = s.bit_q ? dif[27:0] : dbl[27:0];
        return s;
    endfunction

    // one digit of the integer square root
    function automatic t_sqrt_step sqrt_step(input logic [18:0] rem, input logic [16:0] root,
                                             input logic [1:0] pair);
        logic [20:0] cur;
        logic [20:0] trial;
        logic [20:0] dif;
        t_sqrt_step  s;
        cur   = {rem, pair};
        trial = {2'b00, root, 2'b01};
        dif   = cur - trial;
        if (cur >= trial) begin
            s.rem  = dif[18:0];
            s.root = {root[15:0], 1'b1};
        end else begin
            s.rem  = cur[18:0];
            s.root = {root[15:0], 1'b0};
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cgt_div.sv =====
// cgt_div: pipelined restoring divider, floor(num * 2^32 / den), one quotient bit a stage.
// Depends on cgt_pkg.
`default_nettype none
module cgt_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire logic [25:0]   i_num,
    input  wire logic [27:0]   i_den,
    input  wire cgt_pkg::t_tag i_tag,
    output logic               o_valid,
    output logic [32:0]        o_quot,
    output logic               o_zero,
    output cgt_pkg::t_tag      o_tag
);
    localparam int N = cgt_pkg::DIV_STAGES;

    logic          r_v    [N];
    logic [27:0]   r_rem  [N];
    logic [32:0]   r_q    [N];
    logic [27:0]   r_den  [N];
    cgt_pkg::t_tag r_tag  [N];

    // integer part is 0 or 1 since num never exceeds den
    logic        n_q0;
    logic [27:0] n_rem0;
    assign n_q0   = ({2'b00, i_num} >= i_den);
    assign n_rem0 = n_q0 ? ({2'b00, i_num} - i_den) : {2'b00, i_num};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= n_rem0;
            r_q[0]   <= {32'd0, n_q0};
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k < N; k++) begin : g_stage
        cgt_pkg::t_div_step n_step;
        always_comb n_step = cgt_pkg::div_step(r_rem[k-1], r_den[k-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k] <= n_step.rem;
                r_q[k]   <= {r_q[k-1][31:0], n_step.bit_q};
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quot  = r_q[N-1];
    assign o_zero  = (r_rem[N-1] == 28'd0);
    assign o_tag   = r_tag[N-1];
endmodule
`default_nettype wire

// ===== rtl/core/cgt_sqrt.sv =====
// cgt_sqrt: pipelined integer square root of a 33-bit value, one root bit a stage.
// Depends on cgt_pkg.
`default_nettype none
module cgt_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire logic [32:0]   i_rad,
    input  wire logic          i_zero,
    input  wire cgt_pkg::t_tag i_tag,
    output logic               o_valid,
    output logic [16:0]        o_root,
    output logic               o_exact,
    output cgt_pkg::t_tag      o_tag
);
    localparam int N = cgt_pkg::SQRT_STAGES;

    logic          r_v    [N];
    logic [18:0]   r_rem  [N];
    logic [16:0]   r_root [N];
    logic [33:0]   r_rad  [N];
    logic          r_zero [N];
    cgt_pkg::t_tag r_tag  [N];

    cgt_pkg::t_sqrt_step n_step0;
    always_comb n_step0 = cgt_pkg::sqrt_step(19'd0, 17'd0, {1'b0, i_rad[32]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0]  <= n_step0.rem;
            r_root[0] <= n_step0.root;
            r_rad[0]  <= {1'b0, i_rad};
            r_zero[0] <= i_zero;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 1; k < N; k++) begin : g_stage
        cgt_pkg::t_sqrt_step n_step;
        always_comb n_step = cgt_pkg::sqrt_step(r_rem[k-1], r_root[k-1],
                                                r_rad[k-1][2*(N-1-k)+1 -: 2]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k]  <= n_step.rem;
                r_root[k] <= n_step.root;
                r_rad[k]  <= r_rad[k-1];
                r_zero[k] <= r_zero[k-1];
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_exact = r_zero[N-1] && (r_rem[N-1] == 19'd0);
    assign o_tag   = r_tag[N-1];
endmodule
`default_nettype wire

// ===== rtl/core/cgt_blend.sv =====
// cgt_blend: turns the root into the weight t and blends bottom to top colour into bytes.
// Depends on cgt_pkg. Three register stages; the last is the output register.
`default_nettype none
module cgt_blend (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic            i_valid,
    input  wire logic [16:0]     i_root,
    input  wire logic            i_exact,
    input  wire cgt_pkg::t_tag   i_tag,
    input  wire cgt_pkg::t_color i_top,
    input  wire cgt_pkg::t_color i_bottom,
    output logic                 o_valid,
    output cgt_pkg::t_pixel      o_pixel
);
    // weight
    logic [16:0] n_t;
    logic [17:0] n_k;
    always_comb begin
        n_k = {1'b0, i_root} + {17'd0, ~i_exact};   // ceiling of the real root
        if (i_tag.up) begin
            n_t = cgt_pkg::ONE_Q;
        end else if (i_tag.neg) begin
            n_t = cgt_pkg::HALF_Q - n_k[17:1] - {16'd0, n_k[0]};
        end else begin
            n_t = cgt_pkg::HALF_Q + {1'b0, i_root[16:1]};
        end
    end

    logic        r_v1, r_v2, r_v3;
    logic [16:0] r_t;
    logic [33:0] r_pb [3];
    logic [33:0] r_pt [3];
    cgt_pkg::t_pixel r_pixel;

    logic [16:0] w_top [3];
    logic [16:0] w_bot [3];
    assign w_top[0] = i_top.red;
    assign w_top[1] = i_top.green;
    assign w_top[2] = i_top.blue;
    assign w_bot[0] = i_bottom.red;
    assign w_bot[1] = i_bottom.green;
    assign w_bot[2] = i_bottom.blue;

    logic [16:0] w_omt;
    assign w_omt = cgt_pkg::ONE_Q - r_t;

    logic [7:0] n_byte [3];
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [34:0] w_sum;
        logic [42:0] w_scl;
        assign w_sum = {1'b0, r_pb[c]} + {1'b0, r_pt[c]};
        assign w_scl = {w_sum, 8'd0} - {8'd0, w_sum};
        assign n_byte[c] = (w_scl[42:40] != 3'd0) ? 8'hFF : w_scl[39:32];

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_pb[c] <= w_bot[c] * w_omt;
                r_pt[c] <= w_top[c] * r_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t           <= n_t;
            r_pixel.red   <= n_byte[0];
            r_pixel.green <= n_byte[1];
            r_pixel.blue  <= n_byte[2];
            r_pixel.alpha <= 8'hFF;
        end
    end

    assign o_valid = r_v3;
    assign o_pixel = r_pixel;
endmodule
`default_nettype wire

// ===== rtl/core/cubemap_gradient_texel.sv =====
// cubemap_gradient_texel: top level of the vertical-gradient sky cube-map texel pipeline.
// Depends on cgt_pkg, cgt_div, cgt_sqrt and cgt_blend.
//
// One texel beat (face, column, row) in, one RGBA8 beat out. The block takes a new texel
// every cycle unless the output stalls; each texel passes through 3 front stages
// (input, offsets, squares), 33 divider stages (one quotient bit each, for n^2*2^32/D),
// 17 square root stages (one root bit each) and 3 blend stages ending in the output
// register. All stages advance together; the pipeline holds only while a finished pixel
// waits at the output under stall, and then o_stall is raised. Write configuration only
// while the pipeline is empty; writes to an index above six are ignored.
`default_nettype none
module cubemap_gradient_texel (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire cgt_pkg::t_texel  i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output cgt_pkg::t_pixel       o_data,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [16:0]      i_cfg_data
);
    logic w_adv;

    // configuration
    logic [12:0]     r_face_size;
    cgt_pkg::t_color r_top, r_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_size    <= cgt_pkg::RST_FACE_SIZE;
            r_top.red      <= cgt_pkg::RST_TOP_RED;
            r_top.green    <= cgt_pkg::RST_TOP_GREEN;
            r_top.blue     <= cgt_pkg::RST_TOP_BLUE;
            r_bottom.red   <= cgt_pkg::RST_BOTTOM_RED;
            r_bottom.green <= cgt_pkg::RST_BOTTOM_GREEN;
            r_bottom.blue  <= cgt_pkg::RST_BOTTOM_BLUE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cgt_pkg::CFG_FACE_SIZE:    r_face_size    <= i_cfg_data[12:0];
                cgt_pkg::CFG_TOP_RED:      r_top.red      <= i_cfg_data;
                cgt_pkg::CFG_TOP_GREEN:    r_top.green    <= i_cfg_data;
                cgt_pkg::CFG_TOP_BLUE:     r_top.blue     <= i_cfg_data;
                cgt_pkg::CFG_BOTTOM_RED:   r_bottom.red   <= i_cfg_data;
                cgt_pkg::CFG_BOTTOM_GREEN: r_bottom.green <= i_cfg_data;
                cgt_pkg::CFG_BOTTOM_BLUE:  r_bottom.blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // stage 1: input register
    logic            r_v1;
    cgt_pkg::t_texel r_in;

    // stage 2: centered offsets and numerator
    logic           r_v2;
    logic [13:0]    r_amag, r_nmag;
    cgt_pkg::t_tag  r_tag2;

    // stage 3: squares (a^2 + b^2 needs one bit more than a single square)
    logic           r_v3;
    logic [26:0]    r_a2;
    logic [25:0]    r_n2, r_r2;
    cgt_pkg::t_tag  r_tag3;

    logic signed [14:0] w_a, w_b;
    logic [14:0]        w_amag, w_bmag;
    logic               w_up;
    cgt_pkg::t_tag      n_tag;
    logic [13:0]        n_nmag;

    assign w_a    = $signed({2'b00, r_in.column, 1'b1}) - $signed({2'b00, r_face_size});
    assign w_b    = $signed({2'b00, r_in.row, 1'b1}) - $signed({2'b00, r_face_size});
    assign w_amag = w_a[14] ? 15'(-w_a) : w_a;
    assign w_bmag = w_b[14] ? 15'(-w_b) : w_b;
    assign w_up   = (r_in.face > cgt_pkg::FACE_LAST);

    always_comb begin
        n_tag.up = w_up;
        if (r_in.face == cgt_pkg::FACE_POS_Y) begin
            n_tag.neg = 1'b0;
            n_nmag    = {1'b0, r_face_size};
        end else if (r_in.face == cgt_pkg::FACE_NEG_Y) begin
            n_tag.neg = 1'b1;
            n_nmag    = {1'b0, r_face_size};
        end else begin
            // side faces: numerator is -b
            n_tag.neg = !w_b[14] && (w_b != 15'sd0);
            n_nmag    = w_bmag[13:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    logic [13:0] r_bmag;
    logic [12:0] r_res2;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in   <= i_data;
            r_amag <= w_amag[13:0];
            r_bmag <= w_bmag[13:0];
            r_nmag <= n_nmag;
            r_res2 <= r_face_size;
            r_tag2 <= n_tag;
            r_a2   <= 27'(r_amag * r_amag) + 27'(r_bmag * r_bmag);
            r_r2   <= 26'(r_res2 * r_res2);
            r_n2   <= 26'(r_nmag * r_nmag);
            r_tag3 <= r_tag2;
        end
    end

    logic [27:0] w_den;
    assign w_den = {1'b0, r_a2} + {2'b00, r_r2};

    logic          w_dv, w_dzero;
    logic [32:0]   w_quot;
    cgt_pkg::t_tag w_dtag;

    cgt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_v3),
        .i_num   (r_n2),
        .i_den   (w_den),
        .i_tag   (r_tag3),
        .o_valid (w_dv),
        .o_quot  (w_quot),
        .o_zero  (w_dzero),
        .o_tag   (w_dtag)
    );

    logic          w_sv, w_exact;
    logic [16:0]   w_root;
    cgt_pkg::t_tag w_stag;

    cgt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_dv),
        .i_rad   (w_quot),
        .i_zero  (w_dzero),
        .i_tag   (w_dtag),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_exact (w_exact),
        .o_tag   (w_stag)
    );

    cgt_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (w_sv),
        .i_root   (w_root),
        .i_exact  (w_exact),
        .i_tag    (w_stag),
        .i_top    (r_top),
        .i_bottom (r_bottom),
        .o_valid  (o_valid),
        .o_pixel  (o_data)
    );
endmodule
`default_nettype wire

// ===== rtl/core/cgt_checker.sv =====
// cgt_checker: port-level assertions for cubemap_gradient_texel, bound to the top level.
// Depends on cgt_pkg and cubemap_gradient_texel_defines.svh.
`default_nettype none
`include "cubemap_gradient_texel_defines.svh"
module cgt_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_stall,
    input wire logic            o_valid,
    input wire logic            i_stall,
    input wire cgt_pkg::t_pixel o_data
);
    // the only reason to hold the input is a pixel waiting under stall
    `CGT_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "input held without a waiting pixel")
    // alpha is constant on every output beat
    `CGT_ASSERT(a_alpha, i_clk, i_rst_n, o_valid |-> (o_data.alpha == 8'hFF), "alpha not 255")
    // a pixel waiting under stall stays put
    `CGT_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_data)), "stalled pixel changed")
    // reset empties the pipeline
    `CGT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid right after reset")
endmodule

bind cubemap_gradient_texel cgt_checker u_cgt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
`default_nettype wire

// ===== test/cubemap_gradient_texel_checker.sv =====
// cubemap_gradient_texel_checker: watches texel and pixel beats and the config port,
// predicts each pixel exactly and compares it field by field. Depends on cgt_pkg.
module cubemap_gradient_texel_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_stall_in,
    input  cgt_pkg::t_texel i_texel,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  cgt_pkg::t_pixel i_pixel,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_index,
    input  logic [16:0]     i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cgt_pkg::*;

    localparam longint ONE = 65536;

    logic [12:0] face_size;
    t_color      sky_rgb;
    t_color      ground_rgb;
    t_pixel      pixel_queue[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pixel_queue.size();

    // (2t - ONE) * sqrt(d) <= ONE * n, squared with signs handled
    function automatic bit weight_fits(longint tq, longint n, longint d);
        longint      l;
        longint      lmag;
        longint      nmag;
        logic [127:0] lhs;
        logic [127:0] rhs;
        l    = 2 * tq - ONE;
        lmag = l < 0 ? -l : l;
        nmag = n < 0 ? -n : n;
        lhs  = 128'(lmag * lmag) * 128'(d);
        rhs  = 128'(ONE * ONE) * 128'(nmag * nmag);
        if (n >= 0) begin
            if (l <= 0) return 1'b1;
            return lhs <= rhs;
        end
        if (l >= 0) return 1'b0;
        return lhs >= rhs;
    endfunction

    function automatic logic [7:0] blend_byte(longint bottom, longint top, longint tq);
        longint c;
        longint v;
        c = bottom * (ONE - tq) + top * tq;
        v = (c * 255) >>> 32;
        return v > 255 ? 8'd255 : 8'(v);
    endfunction

    function automatic t_pixel predict_pixel(t_texel tx);
        longint res;
        longint a;
        longint b;
        longint d;
        longint n;
        longint lo;
        longint hi;
        longint mid;
        t_pixel px;
        res = face_size;
        if (tx.face > FACE_LAST) begin
            lo = ONE;
        end else begin
            a = 2 * longint'(tx.column) + 1 - res;
            b = 2 * longint'(tx.row) + 1 - res;
            d = a * a + b * b + res * res;
            if (tx.face == FACE_POS_Y) n = res;
            else if (tx.face == FACE_NEG_Y) n = -res;
            else n = -b;
            lo = 0;
            hi = ONE;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (weight_fits(mid, n, d)) lo = mid;
                else hi = mid - 1;
            end
        end
        px.red   = blend_byte(ground_rgb.red, sky_rgb.red, lo);
        px.green = blend_byte(ground_rgb.green, sky_rgb.green, lo);
        px.blue  = blend_byte(ground_rgb.blue, sky_rgb.blue, lo);
        px.alpha = 8'd255;
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            face_size        = RST_FACE_SIZE;
            sky_rgb.red      = RST_TOP_RED;
            sky_rgb.green    = RST_TOP_GREEN;
            sky_rgb.blue     = RST_TOP_BLUE;
            ground_rgb.red   = RST_BOTTOM_RED;
            ground_rgb.green = RST_BOTTOM_GREEN;
            ground_rgb.blue  = RST_BOTTOM_BLUE;
            pixel_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FACE_SIZE:    face_size        = i_cfg_data[12:0];
                    CFG_TOP_RED:      sky_rgb.red      = i_cfg_data;
                    CFG_TOP_GREEN:    sky_rgb.green    = i_cfg_data;
                    CFG_TOP_BLUE:     sky_rgb.blue     = i_cfg_data;
                    CFG_BOTTOM_RED:   ground_rgb.red   = i_cfg_data;
                    CFG_BOTTOM_GREEN: ground_rgb.green = i_cfg_data;
                    CFG_BOTTOM_BLUE:  ground_rgb.blue  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch("unexpected pixel beat", 1, 0);
                end else begin
                    want = pixel_queue.pop_front();
                    if (i_pixel.red !== want.red)
                        report_mismatch("red", i_pixel.red, want.red);
                    if (i_pixel.green !== want.green)
                        report_mismatch("green", i_pixel.green, want.green);
                    if (i_pixel.blue !== want.blue)
                        report_mismatch("blue", i_pixel.blue, want.blue);
                    if (i_pixel.alpha !== want.alpha)
                        report_mismatch("alpha", i_pixel.alpha, want.alpha);
                end
            end
            if (i_valid && !i_stall_in) pixel_queue.push_back(predict_pixel(i_texel));
        end
    end
endmodule

// ===== test/cubemap_gradient_texel_test.sv =====
// cubemap_gradient_texel_test: drives texels and config writes into the sky texel block
// and gives the verdict. Depends on cgt_pkg, the block and cubemap_gradient_texel_checker.
module cubemap_gradient_texel_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cgt_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN      = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_texel      i_data;
    logic        o_valid;
    logic        i_stall;
    t_pixel      o_data;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [16:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    int          res;
    int          idle_cycles;

    cubemap_gradient_texel u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    cubemap_gradient_texel_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_texel(i_data), .i_out_valid(o_valid), .i_out_stall(i_stall), .i_pixel(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stall, or one long hold when asked
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] index, logic [16:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_texel(logic [2:0] face, logic [11:0] column, logic [11:0] row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data.face   <= face;
        i_data.column <= column;
        i_data.row    <= row;
        do @(posedge i_clk); while (o_stall);
    endtask

    // wait for every pixel, then let the pipeline empty
    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_phase(int size, logic [16:0] tr, logic [16:0] tg, logic [16:0] tb,
                             logic [16:0] br, logic [16:0] bg, logic [16:0] bb);
        res = size;
        write_reg(CFG_FACE_SIZE, 17'(size));
        write_reg(CFG_TOP_RED, tr);
        write_reg(CFG_TOP_GREEN, tg);
        write_reg(CFG_TOP_BLUE, tb);
        write_reg(CFG_BOTTOM_RED, br);
        write_reg(CFG_BOTTOM_GREEN, bg);
        write_reg(CFG_BOTTOM_BLUE, bb);
        write_reg(3'd7, 17'h1ffff);
    endtask

    task automatic random_texels(int count);
        logic [11:0] c;
        logic [11:0] r;
        repeat (count) begin
            if (res > 0 && $urandom_range(0, 9) < 8) begin
                c = 12'($urandom_range(0, (res > 4096 ? 4096 : res) - 1));
                r = 12'($urandom_range(0, (res > 4096 ? 4096 : res) - 1));
            end else begin
                c = 12'($urandom);
                r = 12'($urandom);
            end
            send_texel(3'($urandom_range(0, 7)), c, r);
        end
    endtask

    initial begin
        logic [11:0] edge_pos;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_FACE_SIZE;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 46;
        res         = RST_FACE_SIZE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset colors: two corners on every face code, then center and far texels
        for (int f = 0; f < 8; f++) begin
            send_texel(3'(f), 12'd0, 12'd0);
            send_texel(3'(f), 12'd255, 12'd255);
        end
        send_texel(3'd0, 12'd128, 12'd127);
        send_texel(3'd1, 12'd4095, 12'd4095);
        send_texel(3'd4, 12'd0, 12'd4095);
        send_texel(3'd5, 12'd4095, 12'd0);
        random_texels(150);
        drain_pipe();

        for (int p = 1; p < 8; p++) begin
            if (p == 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 13;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                1: set_phase(1, 17'd0, 17'd0, 17'd0, 17'd65536, 17'd65536, 17'd65536);
                2: set_phase(4096, 17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd0, 17'd0);
                3: set_phase(0, 17'h1ffff, 17'h1ffff, 17'h1ffff,
                             17'h1ffff, 17'h1ffff, 17'h1ffff);
                4: set_phase(8191, 17'd65536, 17'd0, 17'd40000, 17'd0, 17'd65536, 17'd12345);
                default: set_phase($urandom_range(1, 300),
                                   17'($urandom_range(0, 131071)), 17'($urandom_range(0, 65536)),
                                   17'($urandom_range(0, 65536)), 17'($urandom_range(0, 131071)),
                                   17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)));
            endcase
            // face edges at the current size
            edge_pos = res == 0 ? 12'd0 : 12'((res > 4096 ? 4096 : res) - 1);
            send_texel(3'd0, edge_pos, 12'd0);
            send_texel(3'd3, 12'd0, edge_pos);
            send_texel(3'd2, edge_pos, edge_pos);
            if (p == 2) begin
                hold_req = 1'b1;
                random_texels(100);
            end
            random_texels(175);
            drain_pipe();
        end

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cgt_pkg.sv
rtl/core/cgt_div.sv
rtl/core/cgt_sqrt.sv
rtl/core/cgt_blend.sv
rtl/core/cubemap_gradient_texel.sv
rtl/core/cgt_checker.sv
test/cubemap_gradient_texel_checker.sv
test/cubemap_gradient_texel_test.sv
